>>> sv/ctcc_pkg.sv
// Package: item types, opcodes, status codes and constants of the chunked transfer CRC checker.
package ctcc_pkg;

	// Largest chunk length accepted on a chunk header
	localparam int unsigned MAX_CHUNK_BYTES = 4096;
	// Reflected CRC-32 polynomial (IEEE)
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// Opcodes
	localparam logic [1:0] OP_START    = 2'd0;
	localparam logic [1:0] OP_CHUNK    = 2'd1;
	localparam logic [1:0] OP_DATA     = 2'd2;
	localparam logic [1:0] OP_COMPLETE = 2'd3;

	// Status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_BAD_META    = 4'd1;
	localparam logic [3:0] ST_UNEXP_CHUNK = 4'd2;
	localparam logic [3:0] ST_ORDER       = 4'd3;
	localparam logic [3:0] ST_OVERSIZE    = 4'd4;
	localparam logic [3:0] ST_UNEXP_DONE  = 4'd5;
	localparam logic [3:0] ST_INVALID     = 4'd6;
	localparam logic [3:0] ST_RECEIVED    = 4'd7;
	localparam logic [3:0] ST_STRAY       = 4'd8;

	// Input item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] trans_id;
		logic [31:0] total_size;
		logic [31:0] expected_crc;
		logic [31:0] chunk_number;
		logic [12:0] chunk_length;
		logic [7:0]  data_byte;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [3:0]  status;
		logic        transfer_active;
		logic [31:0] bytes_received;
		logic [31:0] crc_value;
	} out_item_t;

endpackage

>>> sv/ctcc_crc_byte.sv
// One-byte update of a finished reflected CRC-32, unrolled into XOR logic.
module ctcc_crc_byte
	import ctcc_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	// Undo the final inversion, shift in eight bits, invert again
	always_comb begin
		logic [31:0] c;
		c = ~crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		crc_out = ~c;
	end

endmodule

>>> sv/ctcc_core.sv
// Transfer state, per-item checks and result formation.
module ctcc_core
	import ctcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        accept,
	input  in_item_t    item,
	output out_item_t   result
);

	logic [31:0] max_size_q;
	logic        active_q;
	logic [63:0] id_q;
	logic [31:0] size_goal_q;
	logic [31:0] crc_goal_q;
	logic [31:0] next_chunk_q;
	logic [31:0] byte_count_q;
	logic [31:0] crc_q;
	logic [12:0] left_q;

	logic        active_d;
	logic [63:0] id_d;
	logic [31:0] size_goal_d;
	logic [31:0] crc_goal_d;
	logic [31:0] next_chunk_d;
	logic [31:0] byte_count_d;
	logic [31:0] crc_d;
	logic [12:0] left_d;
	logic [3:0]  status_d;

	logic [31:0] crc_next;
	logic        id_match;
	logic        over_chunk;
	logic [32:0] size_sum;

	ctcc_crc_byte u_crc (
		.crc_in (crc_q),
		.data   (item.data_byte),
		.crc_out(crc_next)
	);

	assign id_match   = active_q && (id_q == item.trans_id);
	assign over_chunk = {19'd0, item.chunk_length} > 32'(MAX_CHUNK_BYTES);
	assign size_sum   = {1'b0, byte_count_q} + {20'd0, item.chunk_length};

	// Next state and status for the item
	always_comb begin
		active_d     = active_q;
		id_d         = id_q;
		size_goal_d  = size_goal_q;
		crc_goal_d   = crc_goal_q;
		next_chunk_d = next_chunk_q;
		byte_count_d = byte_count_q;
		crc_d        = crc_q;
		left_d       = left_q;
		status_d     = ST_OK;
		case (item.opcode)
			OP_START: begin
				if ((item.total_size == 32'd0) || (item.total_size > max_size_q)) begin
					status_d = ST_BAD_META;
				end else begin
					active_d     = 1'b1;
					id_d         = item.trans_id;
					size_goal_d  = item.total_size;
					crc_goal_d   = item.expected_crc;
					next_chunk_d = 32'd0;
					byte_count_d = 32'd0;
					crc_d        = 32'd0;
					left_d       = 13'd0;
				end
			end
			OP_CHUNK: begin
				if (!id_match) begin
					status_d = ST_UNEXP_CHUNK;
				end else if (item.chunk_number != next_chunk_q) begin
					status_d = ST_ORDER;
				end else if (over_chunk || (size_sum > {1'b0, size_goal_q})) begin
					status_d = ST_OVERSIZE;
				end else begin
					left_d       = item.chunk_length;
					next_chunk_d = next_chunk_q + 32'd1;
				end
			end
			OP_DATA: begin
				if (!active_q || (left_q == 13'd0)) begin
					status_d = ST_STRAY;
				end else begin
					crc_d        = crc_next;
					byte_count_d = byte_count_q + 32'd1;
					left_d       = left_q - 13'd1;
				end
			end
			OP_COMPLETE: begin
				if (!id_match) begin
					status_d = ST_UNEXP_DONE;
				end else if ((byte_count_q != size_goal_q) || (crc_q != crc_goal_q)) begin
					status_d = ST_INVALID;
				end else begin
					status_d = ST_RECEIVED;
					active_d = 1'b0;
					left_d   = 13'd0;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		// Order, size and validation errors drop the transfer
		if ((status_d == ST_ORDER) || (status_d == ST_OVERSIZE) || (status_d == ST_INVALID)) begin
			active_d     = 1'b0;
			id_d         = 64'd0;
			size_goal_d  = 32'd0;
			crc_goal_d   = 32'd0;
			next_chunk_d = 32'd0;
			byte_count_d = 32'd0;
			crc_d        = 32'd0;
			left_d       = 13'd0;
		end
	end

	// Result reflects the state after the item
	always_comb begin
		result.status          = status_d;
		result.transfer_active = active_d;
		result.bytes_received  = byte_count_d;
		result.crc_value       = crc_d;
	end

	// Size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			max_size_q <= cfg_wdata;
		end
	end

	// Transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			id_q         <= 64'd0;
			size_goal_q  <= 32'd0;
			crc_goal_q   <= 32'd0;
			next_chunk_q <= 32'd0;
			byte_count_q <= 32'd0;
			crc_q        <= 32'd0;
			left_q       <= 13'd0;
		end else if (accept) begin
			active_q     <= active_d;
			id_q         <= id_d;
			size_goal_q  <= size_goal_d;
			crc_goal_q   <= crc_goal_d;
			next_chunk_q <= next_chunk_d;
			byte_count_q <= byte_count_d;
			crc_q        <= crc_d;
			left_q       <= left_d;
		end
	end

endmodule

>>> sv/ctcc_out_buf.sv
// Result register with a skid entry, so an item is taken while a result waits.
module ctcc_out_buf
	import ctcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      push_ready,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic      main_valid_q;
	logic      skid_valid_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      pop;

	assign pop          = main_valid_q && result_ready;
	assign push_ready   = !skid_valid_q;
	assign result_valid = main_valid_q;
	assign result       = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_item;
			end else begin
				main_q <= push_item;
			end
		end
	end

endmodule

>>> sv/chunked_transfer_crc_checker.sv
// Results are formed combinationally and registered in the result buffer.
// Throughput: one item per cycle while item_ready is high; the state update, with
// its eight-bit CRC step, is combinational; a two-entry buffer parts the sides.
// Reset (arst_n low, asynchronous): no transfer open, counters and CRC zero,
// result buffer empty, size limit 0xFFFFFFFF.
module chunked_transfer_crc_checker
	import ctcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result
);

	logic      accept;
	out_item_t core_result;

	assign accept = item_valid && item_ready;

	// State update and checks
	ctcc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.item     (item),
		.result   (core_result)
	);

	// Result buffering
	ctcc_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept),
		.push_item   (core_result),
		.push_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

`ifndef NO_ASSERTIONS
	// A full skid entry implies a waiting result
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("skid entry held without a result in the main register");

	// After an accepted item, a result is valid in the next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted item produced no result");

	// A received transfer is closed
	a_received_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_RECEIVED)) |-> !result.transfer_active)
		else $error("received status with transfer still open");

	// A dropped transfer reports cleared state
	a_drop_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ((result.status == ST_ORDER) || (result.status == ST_OVERSIZE) ||
		(result.status == ST_INVALID))) |->
		(!result.transfer_active && (result.bytes_received == 32'd0) &&
		(result.crc_value == 32'd0)))
		else $error("dropped transfer did not clear state");
`endif

endmodule
